// File: rtl/assert_macros.svh
// Assertion macros used by the reorder buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock outside reset.
`define PRB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("reorder buffer assertion failed");

// Implication, checked every clock outside reset.
`define PRB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reorder buffer assertion failed");

`endif

// File: rtl/prb_pkg.sv
// Types and constants of the packet reorder buffer.
package prb_pkg;

	localparam int PRB_WINDOW_MAX = 16;

	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_TIMEOUT = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_STATUS  = 2'd3;

	localparam logic [1:0] KIND_PACKET = 2'd0;
	localparam logic [1:0] KIND_GAP    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic REG_WINDOW   = 1'b0;
	localparam logic REG_MAX_HOLD = 1'b1;

	typedef enum logic [1:0] {
		CELL_IDLE,
		CELL_PUT,
		CELL_POP
	} cell_op_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] pay;
		logic [47:0] arr;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		logic     hit;
		entry_t   ent;
	} cell_cmd_t;

endpackage

// File: rtl/prb_cell.sv
// One slot of the sorted store: compares against the key and shifts with its neighbors.
module prb_cell #(
	parameter int WINDOW_MAX = prb_pkg::PRB_WINDOW_MAX,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  prb_pkg::cell_cmd_t              cmd,
	input  logic [$clog2(WINDOW_MAX+1)-1:0] occ,
	input  logic                            prev_lt,
	input  prb_pkg::entry_t                 prev_ent,
	input  prb_pkg::entry_t                 next_ent,
	output logic                            lt,
	output logic                            eq,
	output prb_pkg::entry_t                 ent
);
	import prb_pkg::*;

	localparam int OCC_W = $clog2(WINDOW_MAX + 1);

	entry_t ent_q;
	logic   live;

	assign live = OCC_W'(IDX) < occ;
	assign lt   = live && (ent_q.seq < cmd.ent.seq);
	assign eq   = live && (ent_q.seq == cmd.ent.seq);
	assign ent  = ent_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUT: begin
				if (cmd.hit) begin
					if (eq) begin
						ent_q.pay <= cmd.ent.pay;
						ent_q.arr <= cmd.ent.arr;
					end
				end else if (!lt) begin
					// first slot not below the key takes it, the rest move up
					if (prev_lt)
						ent_q <= cmd.ent;
					else
						ent_q <= prev_ent;
				end
			end
			CELL_POP: ent_q <= next_ent;
			default: ;
		endcase
	end

endmodule

// File: rtl/prb_chain.sv
// Row of store cells with neighbor links and head taps.
module prb_chain #(
	parameter int WINDOW_MAX = prb_pkg::PRB_WINDOW_MAX
) (
	input  logic                            clk,
	input  prb_pkg::cell_cmd_t              cmd,
	input  logic [$clog2(WINDOW_MAX+1)-1:0] occ,
	output logic                            hit,
	output prb_pkg::entry_t                 head,
	output prb_pkg::entry_t                 second
);
	import prb_pkg::*;

	entry_t ent_w  [WINDOW_MAX];
	entry_t prev_w [WINDOW_MAX];
	entry_t next_w [WINDOW_MAX];
	logic   lt_w   [WINDOW_MAX];
	logic   eq_w   [WINDOW_MAX];
	logic   plt_w  [WINDOW_MAX];

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign plt_w[i]  = 1'b1;
			assign prev_w[i] = cmd.ent;
		end else begin : g_mid
			assign plt_w[i]  = lt_w[i-1];
			assign prev_w[i] = ent_w[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_last
			assign next_w[i] = ent_w[i];
		end else begin : g_inner
			assign next_w[i] = ent_w[i+1];
		end

		prb_cell #(
			.WINDOW_MAX(WINDOW_MAX),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.occ(occ),
			.prev_lt(plt_w[i]),
			.prev_ent(prev_w[i]),
			.next_ent(next_w[i]),
			.lt(lt_w[i]),
			.eq(eq_w[i]),
			.ent(ent_w[i])
		);
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < WINDOW_MAX; i++)
			hit = hit | eq_w[i];
	end

	assign head = ent_w[0];

	if (WINDOW_MAX > 1) begin : g_second
		assign second = ent_w[1];
	end else begin : g_single
		assign second = ent_w[0];
	end

endmodule

// File: rtl/packet_reorder_buffer.sv
// Top level of the packet reorder buffer: sequencer, counters and result register.
// Usage:
//   Input channel (in_valid/in_ready) carries mode, sequence_number, payload_tag
//   and now_ms. Output channel (out_valid/out_ready) carries one result per
//   transfer; last_of_run marks the final result of an input item. Items that
//   cause no result produce no transfer.
//   An item is taken in ST_IDLE and executed in ST_EXEC, so the block cannot
//   take a new item while one is in execution. Each further result of a drain
//   or flush is produced in ST_DRAIN or ST_FLUSH; a flush emits every held
//   packet plus its gap results, one per cycle while the output register is
//   free, and the block takes no new item until the last result is loaded into
//   the output register. Held packets live in a row of WINDOW_MAX cells kept
//   sorted by sequence; inserts and pops shift the row by one slot.
//   A direct result is computed in ST_EXEC from the registered item and loaded
//   into the output register; the first result of a flush comes from ST_FLUSH,
//   which follows ST_EXEC. When the receiver stalls, the result stays in the
//   output register and the sequencer waits; nothing is lost.
//   Reset empties the store, clears baseline and counters, and sets
//   window_size to 16 and max_hold_ms to 100. Config writes via cfg_we,
//   cfg_index, cfg_data take effect at once and belong in idle periods.
module packet_reorder_buffer #(
	parameter int WINDOW_MAX = prb_pkg::PRB_WINDOW_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] sequence_number,
	input  logic [15:0] payload_tag,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] out_sequence,
	output logic [15:0] out_payload,
	output logic        last_of_run,
	output logic [31:0] reordered_total,
	output logic [31:0] dropped_total,
	output logic [31:0] gap_total,
	output logic [4:0]  held_count,
	output logic [32:0] expected_next,
	output logic        expected_known
);
	import prb_pkg::*;
	`include "assert_macros.svh"

	localparam int OCC_W = $clog2(WINDOW_MAX + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t      state_q, state_d;
	logic [4:0]  win_q;
	logic [31:0] hold_q;
	logic [1:0]  mode_q;
	logic [31:0] seq_q;
	logic [15:0] pay_q;
	logic [47:0] now_q;
	logic [32:0] exp_q, exp_d;
	logic        known_q, known_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [31:0] reord_q, reord_d, drop_q, drop_d, gap_q, gap_d;
	logic [32:0] cursor_q, cursor_d, start_q, start_d;
	logic [OCC_W-1:0] budget_q, budget_d;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] oseq_q;
	logic [15:0] opay_q;
	logic        last_q;
	logic [31:0] oreord_q, odrop_q, ogap_q;
	logic [4:0]  oheld_q;
	logic [32:0] oexp_q;
	logic        oknown_q;

	logic        emit;
	logic [1:0]  e_kind;
	logic [31:0] e_seq;
	logic [15:0] e_pay;
	logic        e_last;

	cell_cmd_t   cmd;
	logic        hit;
	entry_t      head, second;
	logic        slot_free;
	logic [32:0] exp_eff;
	logic [32:0] head_nx;
	logic [OCC_W-1:0] eff_win;
	logic [47:0] age;

	prb_chain #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_chain (
		.clk(clk),
		.cmd(cmd),
		.occ(occ_q),
		.hit(hit),
		.head(head),
		.second(second)
	);

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign exp_eff   = known_q ? exp_q : {1'b0, seq_q};
	assign head_nx   = {1'b0, head.seq} + 33'd1;
	assign age       = now_q - head.arr;

	always_comb begin
		if (win_q == 5'd0)
			eff_win = OCC_W'(1);
		else if ({1'b0, win_q} > 6'(WINDOW_MAX))
			eff_win = OCC_W'(WINDOW_MAX);
		else
			eff_win = OCC_W'(win_q);
	end

	always_comb begin
		state_d  = state_q;
		exp_d    = exp_q;
		known_d  = known_q;
		occ_d    = occ_q;
		reord_d  = reord_q;
		drop_d   = drop_q;
		gap_d    = gap_q;
		cursor_d = cursor_q;
		start_d  = start_q;
		budget_d = budget_q;
		emit     = 1'b0;
		e_kind   = KIND_PACKET;
		e_seq    = '0;
		e_pay    = '0;
		e_last   = 1'b0;
		cmd.op   = CELL_IDLE;
		cmd.hit  = hit;
		cmd.ent  = '{seq: seq_q, pay: pay_q, arr: now_q};

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_d = ST_IDLE;
					unique case (mode_q)
						MODE_INSERT: begin
							known_d = 1'b1;
							exp_d   = exp_eff;
							if ({1'b0, seq_q} < exp_eff) begin
								drop_d = sat_inc(drop_q);
							end else if ({1'b0, seq_q} == exp_eff) begin
								exp_d  = {1'b0, seq_q} + 33'd1;
								emit   = 1'b1;
								e_seq  = seq_q;
								e_pay  = pay_q;
								e_last = !((occ_q != '0) && ({1'b0, head.seq} == exp_d));
								if (!e_last)
									state_d = ST_DRAIN;
							end else if (hit || (occ_q < OCC_W'(WINDOW_MAX))) begin
								cmd.op = CELL_PUT;
								if (!hit)
									occ_d = occ_q + OCC_W'(1);
								if (occ_d >= eff_win) begin
									start_d  = exp_eff;
									cursor_d = exp_eff;
									budget_d = eff_win;
									state_d  = ST_FLUSH;
								end
							end
						end
						MODE_TIMEOUT: begin
							if ((occ_q != '0) && (now_q >= head.arr) &&
							    (age >= {16'd0, hold_q})) begin
								start_d  = exp_q;
								cursor_d = exp_q;
								budget_d = eff_win;
								state_d  = ST_FLUSH;
							end
						end
						MODE_CLEAR: begin
							occ_d   = '0;
							exp_d   = '0;
							known_d = 1'b0;
							reord_d = '0;
							drop_d  = '0;
							gap_d   = '0;
						end
						MODE_STATUS: begin
							emit   = 1'b1;
							e_kind = KIND_STATUS;
							e_last = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (slot_free) begin
					cmd.op  = CELL_POP;
					reord_d = sat_inc(reord_q);
					exp_d   = head_nx;
					occ_d   = occ_q - OCC_W'(1);
					emit    = 1'b1;
					e_seq   = head.seq;
					e_pay   = head.pay;
					e_last  = !((occ_q > OCC_W'(1)) && ({1'b0, second.seq} == head_nx));
					if (e_last)
						state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					emit = 1'b1;
					if (({1'b0, head.seq} > cursor_q) && (budget_q != '0)) begin
						e_kind   = KIND_GAP;
						gap_d    = sat_inc(gap_q);
						cursor_d = cursor_q + 33'd1;
						budget_d = budget_q - OCC_W'(1);
					end else begin
						cmd.op   = CELL_POP;
						e_seq    = head.seq;
						e_pay    = head.pay;
						if ({1'b0, head.seq} != start_q)
							reord_d = sat_inc(reord_q);
						occ_d    = occ_q - OCC_W'(1);
						exp_d    = head_nx;
						cursor_d = head_nx;
						e_last   = (occ_q == OCC_W'(1));
						if (e_last)
							state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= 5'd16;
			hold_q      <= 32'd100;
			exp_q       <= '0;
			known_q     <= 1'b0;
			occ_q       <= '0;
			reord_q     <= '0;
			drop_q      <= '0;
			gap_q       <= '0;
			cursor_q    <= '0;
			start_q     <= '0;
			budget_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			exp_q    <= exp_d;
			known_q  <= known_d;
			occ_q    <= occ_d;
			reord_q  <= reord_d;
			drop_q   <= drop_d;
			gap_q    <= gap_d;
			cursor_q <= cursor_d;
			start_q  <= start_d;
			budget_q <= budget_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW:   win_q  <= cfg_data[4:0];
					REG_MAX_HOLD: hold_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			seq_q  <= sequence_number;
			pay_q  <= payload_tag;
			now_q  <= now_ms;
		end
		if (emit) begin
			kind_q   <= e_kind;
			oseq_q   <= e_seq;
			opay_q   <= e_pay;
			last_q   <= e_last;
			oreord_q <= reord_d;
			odrop_q  <= drop_d;
			ogap_q   <= gap_d;
			oheld_q  <= 5'(occ_d);
			oexp_q   <= exp_d;
			oknown_q <= known_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign out_sequence    = oseq_q;
	assign out_payload     = opay_q;
	assign last_of_run     = last_q;
	assign reordered_total = oreord_q;
	assign dropped_total   = odrop_q;
	assign gap_total       = ogap_q;
	assign held_count      = oheld_q;
	assign expected_next   = oexp_q;
	assign expected_known  = oknown_q;

	`PRB_ASSERT(a_occ_bound, occ_q <= OCC_W'(WINDOW_MAX))
	`PRB_ASSERT_IMP(a_flush_nonempty, state_q == ST_FLUSH, occ_q != '0)
	`PRB_ASSERT_IMP(a_drain_head, state_q == ST_DRAIN,
		(occ_q != '0) && ({1'b0, head.seq} == exp_q))

endmodule

// File: bench/packet_reorder_buffer_tb.sv
// Self-checking testbench for the packet reorder buffer: directed table, then random traffic.
module packet_reorder_buffer_tb;
	import prb_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic [15:0] pay;
		logic        last;
		logic [31:0] reord;
		logic [31:0] drop;
		logic [31:0] gaps;
		logic [4:0]  held;
		logic [32:0] expn;
		logic        known;
	} result_t;

	typedef struct {
		logic [1:0]  md;
		logic [31:0] sq;
		logic [15:0] pt;
		logic [47:0] nw;
		bit          chk;
		logic [1:0]  k0;
		logic [31:0] s0;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_WINDOW;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_STATUS;
	logic [31:0] sequence_number = '0;
	logic [15:0] payload_tag = '0;
	logic [47:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	result_t     got;

	packet_reorder_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .sequence_number(sequence_number),
		.payload_tag(payload_tag), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(got.kind), .out_sequence(got.seq), .out_payload(got.pay),
		.last_of_run(got.last), .reordered_total(got.reord),
		.dropped_total(got.drop), .gap_total(got.gaps), .held_count(got.held),
		.expected_next(got.expn), .expected_known(got.known)
	);

	always #10 clk = ~clk;

	// reorder model state
	logic [4:0]  win_reg;
	logic [31:0] hold_reg;
	logic [31:0] st_seq [PRB_WINDOW_MAX];
	logic [15:0] st_pay [PRB_WINDOW_MAX];
	logic [47:0] st_arr [PRB_WINDOW_MAX];
	int          st_cnt;
	logic [32:0] next_seq;
	logic        have_base;
	logic [31:0] n_reord, n_drop, n_gap;

	result_t     pending_q[$];
	int          errors = 0;
	bit          idle_on = 1'b1;
	int          hold_off = 0;
	int          quiet = 0;
	stim_t       plan[$];
	logic [47:0] clock_ms = 48'd1000;

	function automatic logic [31:0] sat(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int window_eff();
		if (win_reg == 0) return 1;
		if (win_reg > PRB_WINDOW_MAX) return PRB_WINDOW_MAX;
		return win_reg;
	endfunction

	function automatic void clear_model();
		st_cnt = 0;
		next_seq = '0;
		have_base = 1'b0;
		n_reord = '0;
		n_drop = '0;
		n_gap = '0;
	endfunction

	function automatic void emit(logic [1:0] k, logic [31:0] s, logic [15:0] p);
		result_t r;
		r = '{kind: k, seq: s, pay: p, last: 1'b0, reord: n_reord, drop: n_drop,
			gaps: n_gap, held: st_cnt[4:0], expn: next_seq, known: have_base};
		pending_q.push_back(r);
	endfunction

	function automatic void flush_all();
		logic [32:0] start, cursor;
		longint      budget, holes;
		int          total;
		start = next_seq;
		cursor = start;
		budget = window_eff();
		total = st_cnt;
		for (int i = 0; i < total; i++) begin
			holes = ({1'b0, st_seq[i]} > cursor) ? longint'({1'b0, st_seq[i]} - cursor) : 0;
			if (holes > budget)
				holes = budget;
			for (longint g = 0; g < holes; g++) begin
				n_gap = sat(n_gap);
				emit(KIND_GAP, '0, '0);
			end
			budget -= holes;
			if ({1'b0, st_seq[i]} != start)
				n_reord = sat(n_reord);
			st_cnt--;
			next_seq = {1'b0, st_seq[i]} + 33'd1;
			emit(KIND_PACKET, st_seq[i], st_pay[i]);
			cursor = next_seq;
		end
		st_cnt = 0;
	endfunction

	function automatic void insert_pkt(logic [31:0] s, logic [15:0] p, logic [47:0] t);
		int pos;
		if (!have_base) begin
			next_seq = {1'b0, s};
			have_base = 1'b1;
		end
		if ({1'b0, s} < next_seq) begin
			n_drop = sat(n_drop);
			return;
		end
		if ({1'b0, s} == next_seq) begin
			next_seq = {1'b0, s} + 33'd1;
			emit(KIND_PACKET, s, p);
			while (st_cnt > 0 && {1'b0, st_seq[0]} == next_seq) begin
				logic [31:0] hs;
				logic [15:0] hp;
				hs = st_seq[0];
				hp = st_pay[0];
				for (int j = 1; j < st_cnt; j++) begin
					st_seq[j-1] = st_seq[j];
					st_pay[j-1] = st_pay[j];
					st_arr[j-1] = st_arr[j];
				end
				st_cnt--;
				n_reord = sat(n_reord);
				next_seq = {1'b0, hs} + 33'd1;
				emit(KIND_PACKET, hs, hp);
			end
			return;
		end
		pos = 0;
		while (pos < st_cnt && st_seq[pos] < s)
			pos++;
		if (pos < st_cnt && st_seq[pos] == s) begin
			st_pay[pos] = p;
			st_arr[pos] = t;
		end else begin
			if (st_cnt >= PRB_WINDOW_MAX)
				return;
			for (int j = st_cnt; j > pos; j--) begin
				st_seq[j] = st_seq[j-1];
				st_pay[j] = st_pay[j-1];
				st_arr[j] = st_arr[j-1];
			end
			st_seq[pos] = s;
			st_pay[pos] = p;
			st_arr[pos] = t;
			st_cnt++;
		end
		if (st_cnt >= window_eff())
			flush_all();
	endfunction

	function automatic void predict_item(logic [1:0] m, logic [31:0] s, logic [15:0] p,
		logic [47:0] t);
		int n_prev;
		n_prev = pending_q.size();
		case (m)
			MODE_INSERT: insert_pkt(s, p, t);
			MODE_TIMEOUT: begin
				if (st_cnt > 0 && t >= st_arr[0] && (t - st_arr[0]) >= {16'd0, hold_reg})
					flush_all();
			end
			MODE_CLEAR: clear_model();
			default: emit(KIND_STATUS, '0, '0);
		endcase
		if (pending_q.size() > n_prev)
			pending_q[pending_q.size()-1].last = 1'b1;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %p", got);
			end else begin
				if (got !== pending_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", pending_q[0], got);
				end
				void'(pending_q.pop_front());
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk) begin : rx_ready
		int stall;
		if (!arst_n) begin
			stall = 0;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off--;
			out_ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall = $urandom_range(1, 12) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= 3000) begin
			$display("packet_reorder_buffer_tb: done, errors");
			$finish;
		end
	end

	task automatic send(logic [1:0] m, logic [31:0] s, logic [15:0] p, logic [47:0] t,
		bit chk = 0, logic [1:0] k0 = KIND_PACKET, logic [31:0] s0 = '0);
		int n_prev;
		int gap;
		mode <= m;
		sequence_number <= s;
		payload_tag <= p;
		now_ms <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_prev = pending_q.size();
		predict_item(m, s, p, t);
		if (chk && (pending_q.size() <= n_prev || pending_q[n_prev].kind !== k0
			|| pending_q[n_prev].seq !== s0)) begin
			errors++;
			if (errors <= 10)
				$display("table row mode %0d seq %h: first result not kind %0d seq %h",
					m, s, k0, s0);
		end
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_WINDOW)
			win_reg = d[4:0];
		else
			hold_reg = d;
	endtask

	task automatic run_plan();
		foreach (plan[i])
			send(plan[i].md, plan[i].sq, plan[i].pt, plan[i].nw, plan[i].chk,
				plan[i].k0, plan[i].s0);
		plan.delete();
	endtask

	task automatic random_item();
		int          r;
		logic [31:0] s;
		logic [47:0] t;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			clock_ms = 48'({$urandom, $urandom});
		else
			clock_ms = clock_ms + 48'($urandom_range(0, 40));
		t = ($urandom_range(0, 15) == 0) ? clock_ms - 48'($urandom_range(1, 50)) : clock_ms;
		if (r < 72) begin
			if (!have_base || $urandom_range(0, 19) == 0)
				s = $urandom;
			else if ($urandom_range(0, 9) == 0)
				s = next_seq[31:0] - $urandom_range(1, 4);
			else
				s = next_seq[31:0] + $urandom_range(0, 7);
			send(MODE_INSERT, s, 16'($urandom_range(0, 65535)), t);
		end else if (r < 88) begin
			send(MODE_TIMEOUT, $urandom, 16'($urandom_range(0, 65535)), t);
		end else if (r < 97) begin
			send(MODE_STATUS, $urandom, 16'($urandom_range(0, 65535)), t);
		end else begin
			send(MODE_CLEAR, $urandom, 16'($urandom_range(0, 65535)), t);
		end
	endtask

	initial begin
		logic [4:0]  win_set [6] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8};
		logic [31:0] hold_set [6] = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd10, 32'd20};
		win_reg = 5'd16;
		hold_reg = 32'd100;
		clear_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset settings
		plan.push_back('{MODE_STATUS, 32'h0, 16'h0, 48'd0, 1, KIND_STATUS, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd10, 16'hFFFF, 48'd0, 1, KIND_PACKET, 32'd10});
		plan.push_back('{MODE_INSERT, 32'd5, 16'h1234, 48'd1, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd12, 16'h0001, 48'd5, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd12, 16'h0002, 48'd6, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd14, 16'h0003, 48'd7, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_TIMEOUT, 32'h0, 16'h0, 48'd50, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_TIMEOUT, 32'h0, 16'h0, 48'd0, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_TIMEOUT, 32'h0, 16'h0, 48'd200, 1, KIND_GAP, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd15, 16'hA5A5, 48'd201, 1, KIND_PACKET, 32'd15});
		plan.push_back('{MODE_INSERT, 32'd17, 16'h5A5A, 48'd202, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'd16, 16'h0F0F, 48'd203, 1, KIND_PACKET, 32'd16});
		plan.push_back('{MODE_STATUS, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1,
			KIND_STATUS, 32'h0});
		plan.push_back('{MODE_CLEAR, 32'h0, 16'h0, 48'd0, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_TIMEOUT, 32'h0, 16'h0, 48'd999, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'hFFFF_FFFF, 16'h0, 48'hFFFF_FFFF_FFFF, 1,
			KIND_PACKET, 32'hFFFF_FFFF});
		plan.push_back('{MODE_INSERT, 32'h0, 16'h1, 48'd0, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_INSERT, 32'hFFFF_FFFF, 16'h2, 48'd0, 0, KIND_PACKET, 32'h0});
		plan.push_back('{MODE_STATUS, 32'h0, 16'h0, 48'd0, 1, KIND_STATUS, 32'h0});
		plan.push_back('{MODE_CLEAR, 32'h0, 16'h0, 48'd0, 0, KIND_PACKET, 32'h0});
		run_plan();

		// window of one: every hold flushes at once, one gap at most
		drain_wait();
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_MAX_HOLD, 32'd0);
		plan.push_back('{MODE_INSERT, 32'd100, 16'h7, 48'd10, 1, KIND_PACKET, 32'd100});
		plan.push_back('{MODE_INSERT, 32'd105, 16'h8, 48'd11, 1, KIND_GAP, 32'h0});
		plan.push_back('{MODE_CLEAR, 32'h0, 16'h0, 48'd0, 0, KIND_PACKET, 32'h0});
		run_plan();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			drain_wait();
			write_reg(REG_WINDOW, {27'd0, win_set[ph]});
			write_reg(REG_MAX_HOLD, hold_set[ph]);
			if (ph == 2)
				hold_off = 300;
			if (ph == 5)
				idle_on = 1'b0;
			repeat (13) random_item();
		end

		drain_wait();
		if (errors == 0)
			$display("packet_reorder_buffer_tb: done, clean");
		else
			$display("packet_reorder_buffer_tb: done, errors");
		$finish;
	end

endmodule

// File: packet_reorder_buffer.f
+incdir+rtl
rtl/prb_pkg.sv
rtl/prb_cell.sv
rtl/prb_chain.sv
rtl/packet_reorder_buffer.sv
bench/packet_reorder_buffer_tb.sv
